// File: rtl/core/hdr_exposure_merge_macros.svh
// Assertion macros shared by the checker of the HDR exposure merge block.
// Each macro expands to one labelled concurrent assertion clocked on clk.
`ifndef HDR_EXPOSURE_MERGE_MACROS_SVH
`define HDR_EXPOSURE_MERGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hem assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hem assertion failed");

`endif

// File: rtl/core/hem_pkg.sv
// Package of the HDR exposure merge block: sizes, codes, state type and tables.
// Used by hem_log2, hem_lane, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
package hem_pkg;

    localparam int PIXEL_COUNT = 65536;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int LANES       = 3;
    localparam int LOG_W       = 22;
    localparam int SUM_W       = 40;
    localparam int WT_W        = 21;
    localparam int ENTRY_W     = SUM_W + WT_W;
    localparam int NORM_STEPS  = 31;
    localparam int DIV_STEPS   = 42;
    localparam int CNT_W       = 6;

    localparam logic [15:0] LOW_RESET  = 16'd328;
    localparam logic [15:0] HIGH_RESET = 16'd60293;

    typedef enum logic [1:0] {
        OP_ACC      = 2'd0,
        OP_READ     = 2'd1,
        OP_READ_CLR = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic {
        REG_LOW  = 1'b0,
        REG_HIGH = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'd0,
        ST_IDLE   = 4'd1,
        ST_LOAD   = 4'd2,
        ST_NORM   = 4'd3,
        ST_INTERP = 4'd4,
        ST_MUL    = 4'd5,
        ST_WRITE  = 4'd6,
        ST_DIV    = 4'd7,
        ST_EXP1   = 4'd8,
        ST_EXP2   = 4'd9,
        ST_OUT    = 4'd10
    } state_t;

    typedef struct packed {
        logic start;
        logic capture;
        logic norm;
        logic interp;
        logic mul;
        logic wr_acc;
        logic wr_zero;
        logic div;
        logic exp1;
        logic exp2;
    } lane_ctl_t;

    function automatic logic [16:0] log_tab(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] exp_tab(input logic [4:0] k);
        logic [17:0] v;
        unique case (k)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/hem_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; used by every lane of the HDR exposure merge block.
`timescale 1ns / 1ps
module hem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/hem_log2.sv
// Fixed-point log2 unit: one-bit-a-cycle normalisation while step is high, then table interpolation.
// Depends on hem_pkg for the log table and result width.
`timescale 1ns / 1ps
module hem_log2 import hem_pkg::*; (
    input  logic             clk,
    input  logic             load,
    input  logic [31:0]      x,
    input  logic             step,
    input  logic             interp,
    output logic [LOG_W-1:0] log_val
);

    logic [31:0] n_reg, n_next;
    logic [4:0]  p_reg, p_next;
    logic [32:0] prod_reg, prod_next;
    logic [3:0]  k;
    logic [15:0] r;
    logic [16:0] d;
    logic [32:0] part_w;

    assign k = n_reg[30:27];
    assign r = n_reg[26:11];
    assign d = log_tab({1'b0, k} + 5'd1) - log_tab({1'b0, k});

    always_comb
    begin
        n_next    = n_reg;
        p_next    = p_reg;
        prod_next = prod_reg;
        if (load)
        begin
            n_next = (x == 32'd0) ? 32'd1 : x;
            p_next = 5'd31;
        end
        else if (step && !n_reg[31])
        begin
            n_next = {n_reg[30:0], 1'b0};
            p_next = p_reg - 5'd1;
        end
        if (interp)
        begin
            prod_next = 33'(d * r);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
    end

    // Interpolated part is rounded half up before it joins the table value.
    assign part_w  = prod_reg + 33'd32768;
    assign log_val = LOG_W'({p_reg, 16'h0000}) + LOG_W'(log_tab({1'b0, k}))
                   + LOG_W'(part_w[32:16]);

endmodule

// File: rtl/core/hem_lane.sv
// One colour lane: sample log2, weighted accumulation into its own RAM,
// iterative divide and exp2 for reads. Depends on hem_pkg, hem_log2, hem_ram.
`timescale 1ns / 1ps
module hem_lane import hem_pkg::*; (
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [ADDR_W-1:0] ram_addr,
    input  logic [15:0]       sample,
    input  logic [LOG_W-1:0]  lexp,
    output logic [SUM_W-1:0]  radiance,
    output logic              zero_wt
);

    localparam logic signed [41:0] SUM_MAX = 42'sd549755813887;
    localparam logic signed [41:0] SUM_MIN = -42'sd549755813888;
    localparam logic signed [42:0] M_MIN   = -43'sd2621440;
    localparam logic signed [42:0] M_SAT   = 43'sd524288;

    logic [15:0]             sample_reg;
    logic [LOG_W-1:0]        logv;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
    logic signed [SUM_W-1:0] sum_reg;
    logic [WT_W-1:0]         wt_reg;
    logic signed [40:0]      prod_reg;
    logic [41:0]             quo_reg;
    logic [WT_W-1:0]         rem_reg;
    logic                    neg_reg;
    logic                    sat_reg;
    logic signed [6:0]       i_reg;
    logic [29:0]             t_reg;
    logic [SUM_W-1:0]        rad_reg;

    logic [17:0]             two_v;
    logic [16:0]             dev_mag;
    logic [16:0]             w;
    logic signed [22:0]      diff;
    logic signed [40:0]      term;
    logic signed [41:0]      sum_ext;
    logic [SUM_W-1:0]        sum_sat;
    logic [WT_W:0]           wt_ext;
    logic [WT_W-1:0]         wt_sat;
    logic signed [41:0]      n_init;
    logic [41:0]             mag_init;
    logic [WT_W:0]           rem_sh;
    logic                    ge;
    logic signed [42:0]      q;
    logic signed [42:0]      mc;
    logic [4:0]              ek;
    logic [11:0]             er;
    logic [17:0]             ed;
    logic [29:0]             t_next;
    logic signed [6:0]       s;
    logic [40:0]             up;
    logic [SUM_W-1:0]        rad_next;

    hem_log2 u_log (
        .clk     (clk),
        .load    (ctl.start),
        .x       ({16'h0000, sample}),
        .step    (ctl.norm),
        .interp  (ctl.interp),
        .log_val (logv)
    );

    hem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PIXEL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Hat weight 1 - |2x - 1| in UQ1.16.
    always_comb
    begin
        two_v   = {1'b0, sample_reg, 1'b0};
        dev_mag = (two_v >= 18'd65536) ? 17'(two_v - 18'd65536) : 17'(18'd65536 - two_v);
        w       = 17'(18'd65536 - {1'b0, dev_mag});
        diff    = $signed({1'b0, logv}) - $signed({1'b0, lexp});
    end

    // Accumulate with rounding half up, then saturation of both sums.
    always_comb
    begin
        term    = (prod_reg + 41'sd2) >>> 2;
        sum_ext = 42'(sum_reg) + 42'(term);
        if (sum_ext > SUM_MAX)
        begin
            sum_sat = SUM_MAX[SUM_W-1:0];
        end
        else if (sum_ext < SUM_MIN)
        begin
            sum_sat = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
        wt_ext = {1'b0, wt_reg} + (WT_W + 1)'(w);
        wt_sat = wt_ext[WT_W] ? {WT_W{1'b1}} : wt_ext[WT_W-1:0];
    end

    assign ram_we    = ctl.wr_acc || ctl.wr_zero;
    assign ram_wdata = ctl.wr_zero ? '0 : {sum_sat, wt_sat};

    // Divider set-up and one restoring step of |4 * log_sum| / weight_total.
    always_comb
    begin
        n_init   = {ram_rdata[ENTRY_W-1:WT_W], 2'b00};
        mag_init = ram_rdata[ENTRY_W-1] ? 42'(-n_init) : 42'(n_init);
        rem_sh   = {rem_reg, quo_reg[41]};
        ge       = rem_sh >= {1'b0, wt_reg};
    end

    // Floor quotient, clamped, then table interpolation of the fraction.
    always_comb
    begin
        if (neg_reg)
        begin
            q = -($signed({1'b0, quo_reg}) + 43'(rem_reg != '0));
        end
        else
        begin
            q = $signed({1'b0, quo_reg});
        end
        mc     = (q < M_MIN) ? M_MIN : q;
        ek     = {1'b0, mc[15:12]};
        er     = mc[11:0];
        ed     = exp_tab(ek + 5'd1) - exp_tab(ek);
        t_next = {exp_tab(ek), 12'h000} + 30'(ed * er);
    end

    // Scale by the integer part and saturate into UQ8.32.
    always_comb
    begin
        s  = i_reg + 7'sd4;
        up = 41'(t_reg) << s[3:0];
        if (sat_reg)
        begin
            rad_next = {SUM_W{1'b1}};
        end
        else if (!s[6])
        begin
            rad_next = up[40] ? {SUM_W{1'b1}} : up[SUM_W-1:0];
        end
        else
        begin
            rad_next = SUM_W'(t_reg >> 6'(-s));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sample_reg <= sample;
        end
        if (ctl.capture)
        begin
            sum_reg <= ram_rdata[ENTRY_W-1:WT_W];
            wt_reg  <= ram_rdata[WT_W-1:0];
            neg_reg <= ram_rdata[ENTRY_W-1];
            quo_reg <= mag_init;
            rem_reg <= '0;
        end
        else if (ctl.div)
        begin
            rem_reg <= ge ? WT_W'(rem_sh - {1'b0, wt_reg}) : rem_sh[WT_W-1:0];
            quo_reg <= {quo_reg[40:0], ge};
        end
        if (ctl.mul)
        begin
            prod_reg <= $signed({1'b0, w}) * diff;
        end
        if (ctl.exp1)
        begin
            sat_reg <= q >= M_SAT;
            i_reg   <= mc[22:16];
            t_reg   <= t_next;
        end
        if (ctl.exp2)
        begin
            rad_reg <= rad_next;
        end
    end

    assign zero_wt  = (wt_reg == '0);
    assign radiance = zero_wt ? '0 : rad_reg;

endmodule

// File: rtl/core/hdr_exposure_merge.sv
// HDR exposure merge top level: APB registers, sequencer, lanes and result merge.
// Depends on hem_pkg, hem_log2 and hem_lane.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// operation selects accumulate, read, or read and clear; operation 3 is taken
// and ignored. An accumulate adds one exposure pixel within the thresholds to
// the per-pixel sums and gives no result; busy stays high through the load, the
// 31-step bit-serial normalisation of the log2 units, interpolation, multiply
// and write. A read gives one result, marked by result_valid for exactly one
// cycle; busy stays high through the load, the 42-step iterative divider in
// each lane, exp2 and output. The three colour lanes run side by side, each
// with its own 61-bit RAM, and their outputs are merged into the result ports.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// After reset the thresholds take their reset values and a clearing pass
// writes zero into all 65536 RAM rows, one row a cycle; busy is high during it.
// Configuration writes through the APB port take effect at once, so they are
// to be made only while no transaction is in flight.
`timescale 1ns / 1ps
module hdr_exposure_merge import hem_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [15:0]       pixel_index,
    input  logic [15:0]       sample_red,
    input  logic [15:0]       sample_green,
    input  logic [15:0]       sample_blue,
    input  logic [31:0]       exposure_time,
    output logic              result_valid,
    output logic [15:0]       result_index,
    output logic [SUM_W-1:0]  radiance_red,
    output logic [SUM_W-1:0]  radiance_green,
    output logic [SUM_W-1:0]  radiance_blue,
    output logic              no_valid_sample
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [15:0]         low_reg, high_reg;
    op_t                 op_reg;
    logic [15:0]         idx_reg;
    logic                valid_reg;
    logic                inrange_reg;
    logic                accept;
    logic                in_valid;
    logic                in_range;
    lane_ctl_t           ctl;
    logic [ADDR_W-1:0]   ram_addr;
    logic [LOG_W-1:0]    lexp;
    logic [15:0]         samples  [LANES];
    logic [SUM_W-1:0]    lane_rad [LANES];
    logic [LANES-1:0]    lane_zero;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (reg_idx_t'(paddr[2]) == REG_HIGH) ? {16'h0000, high_reg}
                                                        : {16'h0000, low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_LOW:  low_reg  <= pwdata[15:0];
                REG_HIGH: high_reg <= pwdata[15:0];
                default:  low_reg  <= low_reg;
            endcase
        end
    end

    assign samples[0] = sample_red;
    assign samples[1] = sample_green;
    assign samples[2] = sample_blue;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = 32'(pixel_index) < 32'(PIXEL_COUNT);
    assign in_valid = (sample_red   >= low_reg) && (sample_red   <= high_reg)
                   && (sample_green >= low_reg) && (sample_green <= high_reg)
                   && (sample_blue  >= low_reg) && (sample_blue  <= high_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(operation);
            idx_reg     <= pixel_index;
            valid_reg   <= in_valid;
            inrange_reg <= in_range;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == ADDR_W'(PIXEL_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start && (op_t'(operation) != OP_NONE))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:   state_next = (op_reg == OP_ACC) ? ST_NORM : ST_DIV;
            ST_NORM:   if (cnt_reg == CNT_W'(NORM_STEPS - 1)) state_next = ST_INTERP;
            ST_INTERP: state_next = ST_MUL;
            ST_MUL:    state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            ST_DIV:    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_EXP1;
            ST_EXP1:   state_next = ST_EXP2;
            ST_EXP2:   state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if (((state_reg == ST_NORM) || (state_reg == ST_DIV)) && (state_next == state_reg))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        clr_next = (state_reg == ST_CLEAR) ? clr_reg + ADDR_W'(1) : clr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    // Outputs of the sequencer.
    always_comb
    begin
        ctl          = '0;
        ram_addr     = idx_reg[ADDR_W-1:0];
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_zero = 1'b1;
                ram_addr    = clr_reg;
            end
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctl.start = start;
                ram_addr  = pixel_index[ADDR_W-1:0];
            end
            ST_LOAD:   ctl.capture = 1'b1;
            ST_NORM:   ctl.norm    = 1'b1;
            ST_INTERP: ctl.interp  = 1'b1;
            ST_MUL:    ctl.mul     = 1'b1;
            ST_WRITE:  ctl.wr_acc  = valid_reg && inrange_reg;
            ST_DIV:    ctl.div     = 1'b1;
            ST_EXP1:   ctl.exp1    = 1'b1;
            ST_EXP2:   ctl.exp2    = 1'b1;
            ST_OUT:
            begin
                result_valid = 1'b1;
                ctl.wr_zero  = (op_reg == OP_READ_CLR) && inrange_reg;
            end
            default:   busy = 1'b1;
        endcase
    end

    hem_log2 u_exp_log (
        .clk     (clk),
        .load    (ctl.start),
        .x       (exposure_time),
        .step    (ctl.norm),
        .interp  (ctl.interp),
        .log_val (lexp)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        hem_lane u_lane (
            .clk      (clk),
            .ctl      (ctl),
            .ram_addr (ram_addr),
            .sample   (samples[g]),
            .lexp     (lexp),
            .radiance (lane_rad[g]),
            .zero_wt  (lane_zero[g])
        );
    end

    // Merge of the lane results into one transaction.
    assign result_index    = idx_reg;
    assign radiance_red    = inrange_reg ? lane_rad[0] : '0;
    assign radiance_green  = inrange_reg ? lane_rad[1] : '0;
    assign radiance_blue   = inrange_reg ? lane_rad[2] : '0;
    assign no_valid_sample = !inrange_reg || (|lane_zero);

endmodule

// File: rtl/core/hem_checker.sv
// Port-level checker for the HDR exposure merge block, bound to the top level.
// Depends on hem_pkg and on hdr_exposure_merge_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "hdr_exposure_merge_macros.svh"
module hem_checker import hem_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       result_valid
);

    // A result strobe lasts one cycle only.
    `HEM_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)

    // A result is shown only while the block is still occupied with its item.
    `HEM_ASSERT_NOW(a_strobe_busy, result_valid, busy)

    // A read transaction keeps the block occupied in the following cycle.
    `HEM_ASSERT_NEXT(a_read_busy, start && !busy && (operation == OP_READ || operation == OP_READ_CLR),
                     busy && !result_valid)

    // Busy does not fall straight after an accumulate is accepted.
    `HEM_ASSERT_NEXT(a_accept_hold, start && !busy && operation == OP_ACC, busy)

endmodule

bind hdr_exposure_merge hem_checker u_hem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .result_valid (result_valid)
);

// File: tb/testbench.sv
// Self-checking testbench of the HDR exposure merge block: directed and random
// transactions, a bit-accurate radiance predictor and a result scoreboard.
// Depends on hem_pkg and the hdr_exposure_merge RTL.
`timescale 1ns / 1ps
module testbench import hem_pkg::*; ();

    typedef struct {
        op_t         op;
        logic [15:0] idx;
        logic [15:0] smp [3];
        logic [31:0] expo;
        bit          drain;
    } pixel_item_t;

    typedef struct {
        logic [15:0] idx;
        logic [39:0] rad [3];
        logic        nvs;
    } radiance_t;

    localparam longint SUM_HI  = 64'sd549755813887;
    localparam longint SUM_LO  = -64'sd549755813888;
    localparam longint WT_SAT  = 2097151;
    localparam longint RAD_MAX = 64'hFF_FFFF_FFFF;
    localparam int     WATCHDOG_LIMIT = 300000;

    localparam longint LOG_POINTS [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
        34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    localparam longint EXP_POINTS [17] = '{65536, 68438, 71468, 74632, 77936, 81386,
        84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = '0;
    logic [15:0] pixel_index = '0;
    logic [15:0] sample_red = '0, sample_green = '0, sample_blue = '0;
    logic [31:0] exposure_time = '0;
    logic        result_valid;
    logic [15:0] result_index;
    logic [39:0] radiance_red, radiance_green, radiance_blue;
    logic        no_valid_sample;

    hdr_exposure_merge dut (.*);

    always #4 clk = ~clk;

    // Predictor state: thresholds and per-component sums, keyed by pixel*3+component.
    longint      thr_low = LOW_RESET;
    longint      thr_high = HIGH_RESET;
    longint      log_acc [int];
    longint      weight_acc [int];

    pixel_item_t pending [$];
    radiance_t   expected_radiance [$];
    int          mismatches = 0;
    int          gap = 0;
    bit          calm = 1'b0;
    int          quiet_cycles = 0;

    function automatic longint log2_fixed(longint x);
        longint p, n, frac, k, r, d;
        x = x & 64'hFFFF_FFFF;
        if (x == 0)
            x = 1;
        p = 31;
        while (p > 0 && ((x >> p) & 1) == 0)
            p--;
        n = (x << (31 - p)) & 64'hFFFF_FFFF;
        frac = n & 64'h7FFF_FFFF;
        k = frac >> 27;
        r = (frac >> 11) & 16'hFFFF;
        d = LOG_POINTS[k + 1] - LOG_POINTS[k];
        return p * 65536 + LOG_POINTS[k] + ((d * r + 32768) >> 16);
    endfunction

    function automatic longint exp2_radiance(longint m);
        longint i, f, k, r, t, s;
        if (m < -40 * 65536)
            m = -40 * 65536;
        i = m >>> 16;
        if (i >= 8)
            return RAD_MAX;
        f = m - i * 65536;
        k = (f >> 12) & 15;
        r = f & 12'hFFF;
        t = EXP_POINTS[k] * 4096 + (EXP_POINTS[k + 1] - EXP_POINTS[k]) * r;
        s = i + 4;
        if (s >= 0)
            t = t << s;
        else if (s <= -63)
            t = 0;
        else
            t = t >> (-s);
        return (t > RAD_MAX) ? RAD_MAX : t;
    endfunction

    function automatic void merge_pixel(pixel_item_t it);
        longint v, dev, w, term, sum, wt, lexp, key, q;
        radiance_t res;
        bit ok;
        if (it.op == OP_NONE)
            return;
        if (it.op == OP_ACC) begin
            ok = 1'b1;
            for (int c = 0; c < 3; c++)
                if (it.smp[c] < thr_low || it.smp[c] > thr_high)
                    ok = 1'b0;
            if (!ok)
                return;
            lexp = log2_fixed(it.expo);
            for (int c = 0; c < 3; c++) begin
                key = it.idx * 3 + c;
                v = it.smp[c];
                dev = 2 * v - 65536;
                w = 65536 - (dev < 0 ? -dev : dev);
                term = (w * (log2_fixed(v) - lexp) + 2) >>> 2;
                sum = (log_acc.exists(key) ? log_acc[key] : 0) + term;
                wt = (weight_acc.exists(key) ? weight_acc[key] : 0) + w;
                if (sum > SUM_HI)
                    sum = SUM_HI;
                if (sum < SUM_LO)
                    sum = SUM_LO;
                if (wt > WT_SAT)
                    wt = WT_SAT;
                log_acc[key] = sum;
                weight_acc[key] = wt;
            end
            return;
        end
        res.idx = it.idx;
        res.nvs = 1'b0;
        for (int c = 0; c < 3; c++) begin
            key = it.idx * 3 + c;
            wt = weight_acc.exists(key) ? weight_acc[key] : 0;
            res.rad[c] = '0;
            if (wt == 0) begin
                res.nvs = 1'b1;
            end else begin
                sum = log_acc[key] * 4;
                q = (sum >= 0) ? sum / wt : -((-sum + wt - 1) / wt);
                res.rad[c] = exp2_radiance(q);
            end
            if (it.op == OP_READ_CLR) begin
                log_acc[key] = 0;
                weight_acc[key] = 0;
            end
        end
        expected_radiance.insert(expected_radiance.size(), res);
    endfunction

    function automatic bit drain_done();
        return expected_radiance.size() == 0 && !busy;
    endfunction

    // Driver: presents the head of the pending queue and holds it until taken.
    always @(posedge clk) begin
        pixel_item_t nxt;
        bit taken;
        int pause;
        taken = rst_n && start && !busy;
        pause = 0;
        if (taken) begin
            merge_pixel(pending.pop_front());
            if (!calm && $urandom_range(0, 3) == 0)
                pause = $urandom_range(1, 18);
        end
        if (start && !taken) begin
            start <= 1'b1;
        end else if (pause > 0) begin
            gap <= pause - 1;
            start <= 1'b0;
        end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
        end else if (pending.size() > 0 && rst_n) begin
            nxt = pending[0];
            if (nxt.drain && !(drain_done() && !taken)) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                operation <= nxt.op;
                pixel_index <= nxt.idx;
                sample_red <= nxt.smp[0];
                sample_green <= nxt.smp[1];
                sample_blue <= nxt.smp[2];
                exposure_time <= nxt.expo;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor and watchdog.
    always @(posedge clk) begin
        radiance_t exp_r;
        logic [39:0] got [3];
        if (rst_n && result_valid) begin
            got[0] = radiance_red;
            got[1] = radiance_green;
            got[2] = radiance_blue;
            if (expected_radiance.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d", result_index);
            end else begin
                exp_r = expected_radiance.pop_front();
                if (exp_r.idx !== result_index || exp_r.nvs !== no_valid_sample
                    || exp_r.rad[0] !== got[0] || exp_r.rad[1] !== got[1]
                    || exp_r.rad[2] !== got[2]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %h %h %b, got %0d %h %h %h %b",
                                 exp_r.idx, exp_r.rad[0], exp_r.rad[1], exp_r.rad[2], exp_r.nvs,
                                 result_index, got[0], got[1], got[2], no_valid_sample);
                end
            end
        end
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_item(op_t op, int idx, int r, int g, int b, longint expo, bit drain = 0);
        pixel_item_t it;
        it.op = op;
        it.idx = idx[15:0];
        it.smp[0] = r[15:0];
        it.smp[1] = g[15:0];
        it.smp[2] = b[15:0];
        it.expo = expo[31:0];
        it.drain = drain;
        pending.insert(pending.size(), it);
    endtask

    task automatic settle();
        while (pending.size() != 0 || expected_radiance.size() != 0 || busy || start)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_threshold(reg_idx_t which, int value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(which) << 2;
        pwdata <= $urandom() & 32'hFFFF_0000 | value[15:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == REG_LOW)
            thr_low = value[15:0];
        else
            thr_high = value[15:0];
    endtask

    function automatic int in_band_sample();
        if (thr_low > thr_high || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(thr_high, thr_low);
    endfunction

    function automatic longint random_exposure();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(1, 65535);
            2: return longint'($urandom_range(1, 65535)) << 16;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic random_phase(int count);
        int pool [8];
        int px, roll;
        for (int i = 0; i < 8; i++)
            pool[i] = $urandom_range(0, 65535);
        pool[0] = 0;
        pool[1] = 65535;
        for (int n = 0; n < count; n++) begin
            px = pool[$urandom_range(0, 7)];
            roll = $urandom_range(0, 99);
            if (roll < 65)
                add_item(OP_ACC, px, in_band_sample(), in_band_sample(), in_band_sample(),
                         random_exposure());
            else if (roll < 77)
                add_item(OP_READ, px, $urandom(), $urandom(), $urandom(), $urandom());
            else if (roll < 89)
                add_item(OP_READ_CLR, px, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom_range(0, 15) == 0);
            else if (roll < 93)
                add_item(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            else
                add_item(op_t'($urandom_range(0, 2)), $urandom_range(0, 65535),
                         $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty read, rejected and boundary samples, exposure extremes.
        add_item(OP_READ, 0, 0, 0, 0, 1);
        add_item(OP_ACC, 0, 0, 32768, 32768, 65536);
        add_item(OP_ACC, 0, 32768, 65535, 32768, 65536);
        add_item(OP_ACC, 0, 327, 32768, 32768, 65536);
        add_item(OP_ACC, 0, 328, 60293, 32768, 1);
        add_item(OP_ACC, 0, 32768, 40000, 1000, 32'hFFFF_FFFF);
        add_item(OP_ACC, 0, 50000, 328, 20000, 0);
        add_item(OP_READ, 0, 0, 0, 0, 0);
        add_item(OP_ACC, 65535, 32768, 32768, 32768, 65536);
        add_item(OP_READ_CLR, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF);
        add_item(OP_READ, 65535, 0, 0, 0, 1);
        add_item(OP_NONE, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF);
        add_item(OP_ACC, 4660, 60293, 60293, 60293, 1);
        add_item(OP_READ_CLR, 4660, 0, 0, 0, 1, 1);
        add_item(OP_ACC, 4661, 328, 328, 328, 32'hFFFF_FFFF);
        add_item(OP_READ, 4661, 0, 0, 0, 1);
        add_item(OP_READ_CLR, 0, 0, 0, 0, 1);
        // Enough exposures at full weight to saturate both sums of one pixel.
        for (int n = 0; n < 44; n++)
            add_item(OP_ACC, 777, 32768, 32768, 32768, 32'hFFFF_FFFF);
        add_item(OP_READ, 777, 0, 0, 0, 1);
        for (int n = 0; n < 44; n++)
            add_item(OP_ACC, 778, 60000, 32768, 400, 1);
        add_item(OP_READ_CLR, 778, 0, 0, 0, 1);
        random_phase(180);
        settle();

        write_threshold(REG_LOW, 0);
        write_threshold(REG_HIGH, 65535);
        add_item(OP_ACC, 9, 0, 65535, 1, 1);
        add_item(OP_READ, 9, 0, 0, 0, 1);
        random_phase(180);
        settle();

        write_threshold(REG_LOW, 65535);
        write_threshold(REG_HIGH, 0);
        random_phase(60);
        settle();

        write_threshold(REG_LOW, $urandom_range(0, 20000));
        write_threshold(REG_HIGH, $urandom_range(40000, 65535));
        random_phase(180);
        settle();

        write_threshold(REG_LOW, LOW_RESET);
        write_threshold(REG_HIGH, HIGH_RESET);
        random_phase(60);
        calm = 1'b1;
        random_phase(100);
        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hem_pkg.sv
rtl/core/hem_ram.sv
rtl/core/hem_log2.sv
rtl/core/hem_lane.sv
rtl/core/hdr_exposure_merge.sv
rtl/core/hem_checker.sv
tb/testbench.sv
